[src/qft_pkg.sv]
// shared types, constants and helpers of the quoted field tokenizer
`default_nettype none

package qft_pkg;

  // fixed byte codes
  localparam logic [7:0] QUOTE_BYTE = 8'h27;
  localparam logic [7:0] TAB_BYTE   = 8'h09;
  localparam logic [7:0] LF_BYTE    = 8'h0a;
  localparam logic [7:0] CR_BYTE    = 8'h0d;

  // register file
  localparam int CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_SEPARATOR     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IGNORE_FIRST  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_IGNORE_SECOND = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_IGNORE_THIRD  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_IGNORE_FOURTH = 3'd4;
  localparam logic [7:0] SEPARATOR_RESET = 8'd44;

  // most results one byte can cause
  localparam int MAX_RESULTS = 3;

  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_END  = 2'd1,
    KIND_DONE = 2'd2
  } qft_kind_t;

  typedef struct packed {
    logic [7:0]      separator;
    logic [3:0][7:0] ignore_byte;
  } qft_regs_t;

  typedef struct packed {
    qft_kind_t  kind;
    logic [7:0] char_value;
    logic [6:0] token_index;
    logic [5:0] char_position;
    logic [6:0] token_total;
  } qft_item_t;

  // all results of one input byte, in order
  typedef struct packed {
    logic [1:0]                  count;
    logic                        overflow;
    qft_item_t [MAX_RESULTS-1:0] items;
  } qft_bundle_t;

  // counts leave the block masked to the field widths
  function automatic logic [6:0] to_index(input logic [31:0] value);
    return value[6:0];
  endfunction

  function automatic logic [5:0] to_position(input logic [31:0] value);
    return value[5:0];
  endfunction

endpackage

`default_nettype wire

[src/qft_in_if.sv]
// input byte channel
`default_nettype none

interface qft_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       line_end;

  modport source (output valid, text_byte, line_end, input ready);
  modport sink   (input valid, text_byte, line_end, output ready);
endinterface

`default_nettype wire

[src/qft_out_if.sv]
// result item channel
`default_nettype none

interface qft_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] char_value;
  logic [6:0] token_index;
  logic [5:0] char_position;
  logic [6:0] token_total;
  logic       overflow;
  logic       run_last;

  modport source (output valid, kind, char_value, token_index, char_position,
                  token_total, overflow, run_last, input ready);
  modport sink   (input valid, kind, char_value, token_index, char_position,
                  token_total, overflow, run_last, output ready);
endinterface

`default_nettype wire

[src/qft_cfg_if.sv]
// configuration write channel
`default_nettype none

interface qft_cfg_if import qft_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [7:0]             data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[src/quoted_field_tokenizer.sv]
// top level of the quoted field tokenizer
`default_nettype none

// Splits a text line, one byte per transaction, into tokens at the separator
// register. Every input byte is decided in the cycle it is accepted: the line
// state updates at once and the byte's results (none, or up to three: a kept
// character or token end, a closing token end, and the done item on the last
// byte) go into a two-entry result queue. Input is taken every cycle while
// the queue has room, so bytes with at most one result stream at one per
// cycle if the output is ready; a byte with more results takes a transfer
// for each on the single result port, which bounds the rate. Configuration
// writes are always accepted and should only be made between lines.

module quoted_field_tokenizer import qft_pkg::*; #(
  parameter int TOKEN_CAPACITY = 64,
  parameter int MAX_TOKENS     = 64
) (
  input  logic         clk,
  input  logic         rst,
  qft_cfg_if.sink      cfg,
  qft_in_if.sink       text,
  qft_out_if.source    result
);

  localparam int POS_W = $clog2(TOKEN_CAPACITY);
  localparam int TOK_W = $clog2(MAX_TOKENS + 1);

  qft_regs_t        regs;
  logic [7:0]       previous_byte, previous_byte_next;
  logic             outside_quotes, outside_quotes_next;
  logic [POS_W-1:0] position_in_token, position_in_token_next;
  logic [TOK_W-1:0] tokens_done, tokens_done_next;
  logic             overflow_seen, overflow_seen_next;
  qft_bundle_t      bundle;

  qft_bundle_t      slots [2];
  logic             head, tail;
  logic [1:0]       fill;
  logic [1:0]       sub;
  qft_bundle_t      head_bundle;
  qft_item_t        head_item;
  logic             in_take, push, out_take, pop, item_last;

  // configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.separator   <= SEPARATOR_RESET;
      regs.ignore_byte <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_SEPARATOR:     regs.separator      <= cfg.data;
        REG_IGNORE_FIRST:  regs.ignore_byte[0] <= cfg.data;
        REG_IGNORE_SECOND: regs.ignore_byte[1] <= cfg.data;
        REG_IGNORE_THIRD:  regs.ignore_byte[2] <= cfg.data;
        REG_IGNORE_FOURTH: regs.ignore_byte[3] <= cfg.data;
        default:           regs                <= regs;
      endcase
    end
  end

  // byte decision
  qft_step #(
    .TOKEN_CAPACITY (TOKEN_CAPACITY),
    .MAX_TOKENS     (MAX_TOKENS)
  ) u_step (
    .text_byte              (text.text_byte),
    .line_end               (text.line_end),
    .regs                   (regs),
    .previous_byte          (previous_byte),
    .outside_quotes         (outside_quotes),
    .position_in_token      (position_in_token),
    .tokens_done            (tokens_done),
    .overflow_seen          (overflow_seen),
    .previous_byte_next     (previous_byte_next),
    .outside_quotes_next    (outside_quotes_next),
    .position_in_token_next (position_in_token_next),
    .tokens_done_next       (tokens_done_next),
    .overflow_seen_next     (overflow_seen_next),
    .bundle                 (bundle)
  );

  // handshake decode
  assign text.ready  = (fill != 2'd2);
  assign in_take     = text.valid && text.ready;
  assign push        = in_take && (bundle.count != 2'd0);
  assign head_bundle = slots[head];
  assign head_item   = head_bundle.items[sub];
  assign item_last   = (sub == head_bundle.count - 2'd1);
  assign out_take    = result.valid && result.ready;
  assign pop         = out_take && item_last;

  // line state
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_byte     <= '0;
      outside_quotes    <= 1'b1;
      position_in_token <= '0;
      tokens_done       <= '0;
      overflow_seen     <= 1'b0;
    end else if (in_take) begin
      previous_byte     <= previous_byte_next;
      outside_quotes    <= outside_quotes_next;
      position_in_token <= position_in_token_next;
      tokens_done       <= tokens_done_next;
      overflow_seen     <= overflow_seen_next;
    end
  end

  // result queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[tail] <= bundle;
    end
  end

  // result queue control
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= 1'b0;
      tail <= 1'b0;
      fill <= 2'd0;
      sub  <= 2'd0;
    end else begin
      if (push) begin
        tail <= !tail;
      end
      if (pop) begin
        head <= !head;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
      if (out_take) begin
        sub <= item_last ? 2'd0 : sub + 2'd1;
      end
    end
  end

  // output from the queue head
  assign result.valid         = (fill != 2'd0);
  assign result.kind          = head_item.kind;
  assign result.char_value    = head_item.char_value;
  assign result.token_index   = head_item.token_index;
  assign result.char_position = head_item.char_position;
  assign result.token_total   = head_item.token_total;
  assign result.overflow      = head_bundle.overflow;
  assign result.run_last      = item_last;

endmodule

`default_nettype wire

[src/qft_step.sv]
// per-byte decision logic: next line state and the results of one byte
`default_nettype none

module qft_step import qft_pkg::*; #(
  parameter int  TOKEN_CAPACITY = 64,
  parameter int  MAX_TOKENS     = 64,
  localparam int POS_W          = $clog2(TOKEN_CAPACITY),
  localparam int TOK_W          = $clog2(MAX_TOKENS + 1)
) (
  input  logic [7:0]       text_byte,
  input  logic             line_end,
  input  qft_regs_t        regs,
  input  logic [7:0]       previous_byte,
  input  logic             outside_quotes,
  input  logic [POS_W-1:0] position_in_token,
  input  logic [TOK_W-1:0] tokens_done,
  input  logic             overflow_seen,
  output logic [7:0]       previous_byte_next,
  output logic             outside_quotes_next,
  output logic [POS_W-1:0] position_in_token_next,
  output logic [TOK_W-1:0] tokens_done_next,
  output logic             overflow_seen_next,
  output qft_bundle_t      bundle
);

  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(TOKEN_CAPACITY - 1);
  localparam logic [TOK_W-1:0] TOK_LIMIT = TOK_W'(MAX_TOKENS);

  logic             is_sep, is_tab, is_drop;
  logic             close_a, keep_a, quotes_a;
  logic             a_valid, b_valid;
  qft_item_t        item_a, item_b, item_c;
  logic [POS_W-1:0] pos1, pos2;
  logic [TOK_W-1:0] tok1, tok2;
  logic             ovf1, ovf2;
  logic [1:0]       fill;

  // byte classification in rule order
  always_comb begin
    is_sep  = (text_byte == regs.separator);
    is_tab  = (text_byte == TAB_BYTE);
    is_drop = (text_byte == regs.ignore_byte[0]) || (text_byte == regs.ignore_byte[1]) ||
              (text_byte == regs.ignore_byte[2]) || (text_byte == regs.ignore_byte[3]) ||
              is_tab || (text_byte == LF_BYTE) || (text_byte == CR_BYTE);
    close_a  = 1'b0;
    keep_a   = 1'b0;
    quotes_a = outside_quotes;
    if (is_sep && (previous_byte == regs.separator)) begin
      close_a = 1'b1;
    end else if ((is_sep || is_tab) && (position_in_token == '0)) begin
      // leading separator or tab dropped
      close_a = 1'b0;
    end else if (text_byte == QUOTE_BYTE) begin
      quotes_a = !outside_quotes;
    end else if (is_drop) begin
      close_a = 1'b0;
    end else if (is_sep && outside_quotes) begin
      close_a = 1'b1;
    end else begin
      keep_a = 1'b1;
    end
  end

  // result of the byte itself
  always_comb begin
    item_a  = '0;
    a_valid = 1'b0;
    pos1    = position_in_token;
    tok1    = tokens_done;
    ovf1    = overflow_seen;
    if (close_a) begin
      if (tokens_done < TOK_LIMIT) begin
        a_valid              = 1'b1;
        item_a.kind          = KIND_END;
        item_a.token_index   = to_index(32'(tokens_done));
        item_a.char_position = to_position(32'(position_in_token));
        tok1                 = tokens_done + 1'b1;
      end else begin
        ovf1 = 1'b1;
      end
      pos1 = '0;
    end else if (keep_a) begin
      if (position_in_token >= POS_LIMIT) begin
        ovf1 = 1'b1;
      end else if (tokens_done >= TOK_LIMIT) begin
        ovf1 = 1'b1;
        pos1 = position_in_token + 1'b1;
      end else begin
        a_valid              = 1'b1;
        item_a.kind          = KIND_CHAR;
        item_a.char_value    = text_byte;
        item_a.token_index   = to_index(32'(tokens_done));
        item_a.char_position = to_position(32'(position_in_token));
        pos1                 = position_in_token + 1'b1;
      end
    end
  end

  // close of an open token and done item at the line end
  always_comb begin
    item_b  = '0;
    item_c  = '0;
    b_valid = 1'b0;
    pos2    = pos1;
    tok2    = tok1;
    ovf2    = ovf1;
    if (line_end && (pos1 != '0)) begin
      if (tok1 < TOK_LIMIT) begin
        b_valid              = 1'b1;
        item_b.kind          = KIND_END;
        item_b.token_index   = to_index(32'(tok1));
        item_b.char_position = to_position(32'(pos1));
        tok2                 = tok1 + 1'b1;
      end else begin
        ovf2 = 1'b1;
      end
      pos2 = '0;
    end
    item_c.kind        = KIND_DONE;
    item_c.token_total = to_index(32'(tok2));
  end

  // pack the results in order
  always_comb begin
    bundle = '0;
    fill   = 2'd0;
    if (a_valid) begin
      bundle.items[fill] = item_a;
      fill               = fill + 2'd1;
    end
    if (b_valid) begin
      bundle.items[fill] = item_b;
      fill               = fill + 2'd1;
    end
    if (line_end) begin
      bundle.items[fill] = item_c;
      fill               = fill + 2'd1;
    end
    bundle.count    = fill;
    bundle.overflow = ovf2;
  end

  // line state, cleared after the last byte of a line
  always_comb begin
    if (line_end) begin
      previous_byte_next     = '0;
      outside_quotes_next    = 1'b1;
      position_in_token_next = '0;
      tokens_done_next       = '0;
      overflow_seen_next     = 1'b0;
    end else begin
      previous_byte_next     = text_byte;
      outside_quotes_next    = quotes_a;
      position_in_token_next = pos2;
      tokens_done_next       = tok2;
      overflow_seen_next     = ovf2;
    end
  end

endmodule

`default_nettype wire

[src/qft_checker.sv]
// port-level checks of the quoted field tokenizer and their binding
`default_nettype none

module qft_checker import qft_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] kind,
  input logic [7:0] char_value,
  input logic [6:0] token_index,
  input logic [5:0] char_position,
  input logic [6:0] token_total,
  input logic       overflow,
  input logic       run_last
);

  // a stalled result stays valid and holds all fields but token total and overflow
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(char_value) &&
      $stable(token_index) && $stable(char_position) && $stable(run_last))
    else $error("stalled result changed");

  // no unused kind code
  a_kind_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (kind == KIND_CHAR) || (kind == KIND_END) || (kind == KIND_DONE))
    else $error("result kind out of range");

  // done item closes the transaction group and carries only the count
  a_done_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_DONE) |-> run_last && (char_value == 8'd0) &&
      (token_index == 7'd0) && (char_position == 6'd0))
    else $error("malformed done item");

  // token end items carry neither a token total nor a char value
  a_field_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_END) |-> (token_total == 7'd0) && (char_value == 8'd0))
    else $error("malformed token end item");

  // overflow is sticky within the transactions of one line
  a_overflow_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && overflow && (kind != KIND_DONE) ##1 out_valid |->
      overflow)
    else $error("overflow flag dropped within a line");

endmodule

bind quoted_field_tokenizer qft_checker u_qft_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (result.valid),
  .out_ready     (result.ready),
  .kind          (result.kind),
  .char_value    (result.char_value),
  .token_index   (result.token_index),
  .char_position (result.char_position),
  .token_total   (result.token_total),
  .overflow      (result.overflow),
  .run_last      (result.run_last)
);

`default_nettype wire
